/* rtl/core/pbfe_pkg.sv */
// Shared types, register indexes and helpers for the packet byte field extract unit.
`timescale 1ns / 1ps
`default_nettype none
package pbfe_pkg;

   localparam int unsigned MaxTextChars   = 31;
   localparam int unsigned MaxBinaryBytes = 4;

   localparam int unsigned AccWidth   = 64;
   localparam int unsigned PosWidth   = 16;
   localparam int unsigned DepthWidth = 8;
   localparam int unsigned ValueWidth = 31;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned CsrIndexWidth = 3;

   localparam logic [CsrIndexWidth-1:0] CsrFieldOffset  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrFieldDepth   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrLittleEndian = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrRadixSelect  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrTextMode     = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrValueMask    = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CsrAlignUp      = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CsrApplyMask    = 3'd7;

   localparam logic [1:0] RadixDec = 2'd0;
   localparam logic [1:0] RadixHex = 2'd1;
   localparam logic [1:0] RadixOct = 2'd2;
   localparam logic [1:0] RadixBad = 2'd3;

   localparam logic [7:0] CharNul   = 8'h00;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharLowX  = 8'h78;
   localparam logic [7:0] CharUpX   = 8'h58;

   localparam logic [4:0] NotDigit = 5'd16;

   typedef enum logic [6:0] {
      PhWait   = 7'b0000001,
      PhWs     = 7'b0000010,
      PhSigned = 7'b0000100,
      PhZero   = 7'b0001000,
      PhDigits = 7'b0010000,
      PhDone   = 7'b0100000,
      PhBin    = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [ValueWidth-1:0] field_value;
      logic                  field_error;
   } rsp_type;

   function automatic logic [4:0] digit_of(input logic [7:0] c);
      logic [4:0] d;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = 5'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = 5'(c - 8'h37);
      end else begin
         d = NotDigit;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/packet_byte_field_extract_unit.sv */
// Top level: packet byte field extract unit with register port and request/result channels.
`timescale 1ns / 1ps
`default_nettype none
// Takes one packet byte per clock and returns one result per packet. A byte sits in an
// input register, then one pass of logic (a 64-bit shift-and-add for text digits, or a
// byte insert for binary fields) updates the field state; the last byte also loads the
// result register. Sustained rate is one byte per cycle; a result waiting under stall holds
// only last bytes back, other bytes keep flowing. The user writes registers through the csr
// port (always ready) only while no packet is in flight; the block does not enforce this.
module packet_byte_field_extract_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire pbfe_pkg::req_type           req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output pbfe_pkg::rsp_type                rsp_data,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [pbfe_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire [pbfe_pkg::WordWidth-1:0]     csr_data
);

   localparam logic [7:0] TextLimit = 8'(pbfe_pkg::MaxTextChars);
   localparam logic [7:0] BinLimit  = 8'(pbfe_pkg::MaxBinaryBytes);

   logic [pbfe_pkg::PosWidth-1:0]   cfg_offset_ff;
   logic [pbfe_pkg::DepthWidth-1:0] cfg_depth_ff;
   logic                            cfg_le_ff;
   logic [1:0]                      cfg_radix_ff;
   logic                            cfg_text_ff;
   logic [pbfe_pkg::WordWidth-1:0]  cfg_mask_ff;
   logic                            cfg_align_ff;
   logic                            cfg_apply_ff;

   logic                 s1_valid_ff, s1_valid_in;
   pbfe_pkg::req_type    s1_data_ff;
   logic                 out_valid_ff, out_valid_in;
   pbfe_pkg::rsp_type    out_data_ff, out_data_in;
   logic                 out_free, s1_go, req_take;

   logic [pbfe_pkg::PosWidth-1:0]   pos_ff, pos_in;
   logic [pbfe_pkg::AccWidth-1:0]   acc_ff, acc_in;
   pbfe_pkg::phase_type             phase_ff, phase_in;
   logic [pbfe_pkg::DepthWidth-1:0] taken_ff, taken_in;
   logic                            neg_ff, neg_in, ovf_ff, ovf_in, err_ff, err_in;

   logic [7:0]  b;
   logic [7:0]  limit;
   logic [4:0]  radix, d;
   logic        is_ws, cont;
   logic [67:0] sum;
   logic [pbfe_pkg::AccWidth-1:0] bin_le;
   logic        res_err;
   logic [31:0] val, aligned;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_offset_ff <= '0;
         cfg_depth_ff  <= 8'd1;
         cfg_le_ff     <= 1'b0;
         cfg_radix_ff  <= pbfe_pkg::RadixDec;
         cfg_text_ff   <= 1'b0;
         cfg_mask_ff   <= '0;
         cfg_align_ff  <= 1'b0;
         cfg_apply_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pbfe_pkg::CsrFieldOffset:  cfg_offset_ff <= csr_data[15:0];
            pbfe_pkg::CsrFieldDepth:   cfg_depth_ff  <= csr_data[7:0];
            pbfe_pkg::CsrLittleEndian: cfg_le_ff     <= csr_data[0];
            pbfe_pkg::CsrRadixSelect:  cfg_radix_ff  <= csr_data[1:0];
            pbfe_pkg::CsrTextMode:     cfg_text_ff   <= csr_data[0];
            pbfe_pkg::CsrValueMask:    cfg_mask_ff   <= csr_data;
            pbfe_pkg::CsrAlignUp:      cfg_align_ff  <= csr_data[0];
            pbfe_pkg::CsrApplyMask:    cfg_apply_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_data_ff.last_byte || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_go);

   always_comb begin
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      taken_in = taken_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      err_in   = err_ff;
      cont     = 1'b0;
      b        = s1_data_ff.data_byte;
      limit    = (cfg_depth_ff < TextLimit) ? cfg_depth_ff : TextLimit;
      case (cfg_radix_ff)
         pbfe_pkg::RadixHex: radix = 5'd16;
         pbfe_pkg::RadixOct: radix = 5'd8;
         default:            radix = 5'd10;
      endcase
      d     = pbfe_pkg::digit_of(b);
      is_ws = (b == pbfe_pkg::CharSpace) || (b >= pbfe_pkg::CharTab && b <= pbfe_pkg::CharCr);
      case (cfg_radix_ff)
         pbfe_pkg::RadixHex: sum = {acc_ff, 4'b0} + {63'b0, d};
         pbfe_pkg::RadixOct: sum = {1'b0, acc_ff, 3'b0} + {63'b0, d};
         default:            sum = {1'b0, acc_ff, 3'b0} + {3'b0, acc_ff, 1'b0}
                                   + {63'b0, d};
      endcase
      bin_le = acc_ff | ({56'b0, b} << {taken_ff[1:0], 3'b0});

      if (phase_in == pbfe_pkg::PhWait && pos_ff == cfg_offset_ff) begin
         if (cfg_text_ff) begin
            phase_in = pbfe_pkg::PhWs;
            if (cfg_radix_ff == pbfe_pkg::RadixBad) begin
               err_in = 1'b1;
            end
         end else begin
            phase_in = pbfe_pkg::PhBin;
         end
      end

      case (phase_in)
         pbfe_pkg::PhWait: ;
         pbfe_pkg::PhDone: ;
         pbfe_pkg::PhBin: begin
            if (taken_ff < cfg_depth_ff && taken_ff < BinLimit) begin
               acc_in   = cfg_le_ff ? bin_le : {acc_ff[55:0], b};
               taken_in = taken_ff + 8'd1;
            end
         end
         default: begin
            if (taken_ff >= limit || b == pbfe_pkg::CharNul
                || cfg_radix_ff == pbfe_pkg::RadixBad) begin
               phase_in = pbfe_pkg::PhDone;
            end else begin
               taken_in = taken_ff + 8'd1;
               cont     = 1'b1;
               if (phase_in == pbfe_pkg::PhWs) begin
                  if (is_ws) begin
                     cont = 1'b0;
                  end else begin
                     phase_in = pbfe_pkg::PhSigned;
                     if (b == pbfe_pkg::CharPlus) begin
                        cont = 1'b0;
                     end else if (b == pbfe_pkg::CharMinus) begin
                        neg_in = 1'b1;
                        cont   = 1'b0;
                     end
                  end
               end
               if (cont && phase_in == pbfe_pkg::PhZero
                   && (b == pbfe_pkg::CharLowX || b == pbfe_pkg::CharUpX)) begin
                  phase_in = pbfe_pkg::PhDigits;
                  cont     = 1'b0;
               end
               if (cont) begin
                  if (d >= radix) begin
                     phase_in = pbfe_pkg::PhDone;
                  end else if (phase_in == pbfe_pkg::PhSigned
                               && cfg_radix_ff == pbfe_pkg::RadixHex && d == 5'd0) begin
                     phase_in = pbfe_pkg::PhZero;
                  end else begin
                     phase_in = pbfe_pkg::PhDigits;
                     if (|sum[67:64]) begin
                        ovf_in = 1'b1;
                        acc_in = '1;
                     end else begin
                        acc_in = sum[63:0];
                     end
                  end
               end
            end
         end
      endcase

      res_err = 1'b0;
      val     = '0;
      if (phase_in == pbfe_pkg::PhWait) begin
         res_err = 1'b1;
      end else if (phase_in == pbfe_pkg::PhBin) begin
         if (cfg_depth_ff == '0) begin
            res_err = 1'b1;
         end else if (cfg_depth_ff > BinLimit) begin
            val = '0;
         end else if (taken_in < cfg_depth_ff) begin
            res_err = 1'b1;
         end else begin
            val = acc_in[31:0];
         end
      end else begin
         if (err_in || cfg_radix_ff == pbfe_pkg::RadixBad || ovf_in) begin
            res_err = 1'b1;
         end else if (neg_in && acc_in != '0) begin
            res_err = 1'b1;
         end else begin
            val = acc_in[31:0];
         end
      end
      if (val[31]) begin
         res_err = 1'b1;
      end
      if (cfg_apply_ff && cfg_mask_ff != '0) begin
         val = val & cfg_mask_ff;
      end
      aligned = (val <= 32'd4) ? 32'd4 : ({val[31:2], 2'b00} + 32'd4);
      if (cfg_align_ff) begin
         val = aligned;
      end
      if (val[31]) begin
         res_err = 1'b1;
      end
      out_data_in.field_error = res_err;
      out_data_in.field_value = res_err ? '0 : val[30:0];

      if (s1_data_ff.last_byte) begin
         pos_in   = '0;
         acc_in   = '0;
         phase_in = pbfe_pkg::PhWait;
         taken_in = '0;
         neg_in   = 1'b0;
         ovf_in   = 1'b0;
         err_in   = 1'b0;
      end else if (pos_ff != '1) begin
         pos_in = pos_ff + 16'd1;
      end
   end

   always_comb begin
      if (s1_go && s1_data_ff.last_byte) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         acc_ff       <= '0;
         phase_ff     <= pbfe_pkg::PhWait;
         taken_ff     <= '0;
         neg_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_go) begin
            pos_ff   <= pos_in;
            acc_ff   <= acc_in;
            phase_ff <= phase_in;
            taken_ff <= taken_in;
            neg_ff   <= neg_in;
            ovf_ff   <= ovf_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (s1_go && s1_data_ff.last_byte) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_err_zero_value: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.field_error |-> out_data_ff.field_value == '0)
      else $error("error result carries a nonzero value");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_data_ff.last_byte |=> pos_ff == '0 && phase_ff == pbfe_pkg::PhWait)
      else $error("packet state not cleared after last byte");

   a_bin_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == pbfe_pkg::PhBin |-> taken_ff <= BinLimit)
      else $error("binary byte count past limit");

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> acc_ff == '1)
      else $error("overflowed accumulator not saturated");

   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_data_ff.last_byte && out_valid_ff && rsp_stall |-> !s1_go)
      else $error("last byte advanced over a held result");

endmodule
`default_nettype wire
